// ===== hw/rtl/ecc_pkg.sv =====
// ----------------------------------------------------------------------------
// Error check code generator package
// Shared item types, mode codes and the bytewise CRC-32 step.
// ----------------------------------------------------------------------------
package ecc_pkg;

  localparam logic [2:0] MODE_PARITY   = 3'd0;
  localparam logic [2:0] MODE_PARITY2D = 3'd1;
  localparam logic [2:0] MODE_CRC32    = 3'd2;
  localparam logic [2:0] MODE_HAMMING  = 3'd3;
  localparam logic [2:0] MODE_CHECKSUM = 3'd4;
  localparam logic [2:0] MODE_RESET    = MODE_CRC32;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [15:0] SUM_MASK  = 16'hFFFF;

  localparam logic [5:0] LEN_PARITY   = 6'd1;
  localparam logic [5:0] LEN_COLUMN   = 6'd8;
  localparam logic [5:0] LEN_HAMMING  = 6'd4;
  localparam logic [5:0] LEN_CHECKSUM = 6'd16;
  localparam logic [5:0] LEN_CRC      = 6'd32;

  localparam logic RES_PER_BYTE = 1'b0;
  localparam logic RES_MESSAGE  = 1'b1;

  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QUEUE_CW-1:0] QUEUE_LIMIT = QUEUE_CW'(QUEUE_DEPTH - 2);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_type;
    logic [31:0] code_value;
    logic [5:0]  code_length;
    logic        end_of_codes;
  } out_item_t;

  typedef struct packed {
    logic      push_a;
    logic      push_b;
    out_item_t item_a;
    out_item_t item_b;
  } ecc_push_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = {1'b0, c[31:1]} ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/ecc_core.sv =====
// ----------------------------------------------------------------------------
// Error check code core
// Input register, message accumulators and result formation for one byte.
// ----------------------------------------------------------------------------
module ecc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  ecc_pkg::in_item_t item,
  input  logic [2:0]        code_mode,
  output logic              held,
  output ecc_pkg::ecc_push_t push
);
  import ecc_pkg::*;

  in_item_t    held_item;
  logic [31:0] crc_register;
  logic [15:0] ones_complement_sum;
  logic [7:0]  pending_high_byte;
  logic        odd_byte_phase;
  logic        total_parity;
  logic [7:0]  column_parity;

  logic [31:0] crc_register_next;
  logic [15:0] ones_complement_sum_next;
  logic        total_parity_next;
  logic [7:0]  column_parity_next;
  logic [7:0]  b;
  logic        last;
  logic        row;
  logic [3:0]  ham;
  logic [15:0] word;
  logic [16:0] wide_sum;
  logic [15:0] folded_sum;
  logic        add_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= accept;
    end
    if (accept) begin
      held_item <= item;
    end
  end

  assign b    = held_item.data_byte;
  assign last = held_item.last_byte;
  assign row  = ^b;

  assign total_parity_next  = total_parity ^ row;
  assign column_parity_next = column_parity ^ b;
  assign crc_register_next  = crc_byte(crc_register, b);

  assign word       = odd_byte_phase ? {pending_high_byte, b} : {b, 8'd0};
  assign add_now    = odd_byte_phase | last;
  assign wide_sum   = {1'b0, ones_complement_sum} + {1'b0, word};
  assign folded_sum = wide_sum[15:0] + {15'd0, wide_sum[16]};
  assign ones_complement_sum_next = add_now ? folded_sum : ones_complement_sum;

  assign ham = {b[7] ^ b[6] ^ b[4] ^ b[3] ^ b[1],
                b[7] ^ b[5] ^ b[4] ^ b[2] ^ b[1],
                b[6] ^ b[5] ^ b[4] ^ b[0],
                b[3] ^ b[2] ^ b[1] ^ b[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register        <= CRC_INIT;
      ones_complement_sum <= '0;
      pending_high_byte   <= '0;
      odd_byte_phase      <= 1'b0;
      total_parity        <= 1'b0;
      column_parity       <= '0;
    end else if (held) begin
      if (last) begin
        crc_register        <= CRC_INIT;
        ones_complement_sum <= '0;
        pending_high_byte   <= '0;
        odd_byte_phase      <= 1'b0;
        total_parity        <= 1'b0;
        column_parity       <= '0;
      end else begin
        crc_register        <= crc_register_next;
        ones_complement_sum <= ones_complement_sum_next;
        if (!odd_byte_phase) begin
          pending_high_byte <= b;
        end
        odd_byte_phase      <= ~odd_byte_phase;
        total_parity        <= total_parity_next;
        column_parity       <= column_parity_next;
      end
    end
  end

  always_comb begin
    push = '0;
    push.item_b = '{result_type: RES_MESSAGE, code_value: {24'd0, column_parity_next},
                    code_length: LEN_COLUMN, end_of_codes: 1'b1};
    case (code_mode)
      MODE_PARITY: begin
        push.push_a = held & last;
        push.item_a = '{result_type: RES_MESSAGE, code_value: {31'd0, total_parity_next},
                        code_length: LEN_PARITY, end_of_codes: 1'b1};
      end
      MODE_PARITY2D: begin
        push.push_a = held;
        push.push_b = held & last;
        push.item_a = '{result_type: RES_PER_BYTE, code_value: {31'd0, row},
                        code_length: LEN_PARITY, end_of_codes: 1'b0};
      end
      MODE_CRC32: begin
        push.push_a = held & last;
        push.item_a = '{result_type: RES_MESSAGE, code_value: ~crc_register_next,
                        code_length: LEN_CRC, end_of_codes: 1'b1};
      end
      MODE_HAMMING: begin
        push.push_a = held;
        push.item_a = '{result_type: RES_PER_BYTE, code_value: {28'd0, ham},
                        code_length: LEN_HAMMING, end_of_codes: last};
      end
      MODE_CHECKSUM: begin
        push.push_a = held & last;
        push.item_a = '{result_type: RES_MESSAGE,
                        code_value: {16'd0, ~ones_complement_sum_next & SUM_MASK},
                        code_length: LEN_CHECKSUM, end_of_codes: 1'b1};
      end
      default: begin
        push.push_a = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ecc_out_queue.sv =====
// ----------------------------------------------------------------------------
// Error check code result queue
// Small result FIFO that takes up to two items per cycle and gives one when not stalled.
// ----------------------------------------------------------------------------
module ecc_out_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  ecc_pkg::ecc_push_t           push,
  output logic                         out_valid,
  input  logic                         out_stall,
  output ecc_pkg::out_item_t           out_item,
  output logic [ecc_pkg::QUEUE_CW-1:0] level
);
  import ecc_pkg::*;

  out_item_t           entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] head;
  logic [QUEUE_AW-1:0] tail;
  logic [QUEUE_AW-1:0] tail_plus;
  logic                pop;
  logic [QUEUE_CW-1:0] push_count;

  assign out_valid  = (level != '0);
  assign out_item   = entries[head];
  assign pop        = out_valid & ~out_stall;
  assign tail_plus  = tail + QUEUE_AW'(1);
  assign push_count = QUEUE_CW'(push.push_a) + QUEUE_CW'(push.push_b);

  always_ff @(posedge clk) begin
    if (push.push_a) begin
      entries[tail] <= push.item_a;
    end
    if (push.push_b) begin
      entries[tail_plus] <= push.item_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      level <= '0;
    end else begin
      tail  <= tail + QUEUE_AW'(push_count);
      head  <= head + QUEUE_AW'(pop);
      level <= level + push_count - QUEUE_CW'(pop);
    end
  end

endmodule

// ===== hw/rtl/error_check_code_generator.sv =====
// ----------------------------------------------------------------------------
// Error check code generator
// Parity, two-dimensional parity, CRC-32, Hamming and Internet checksum
// codes over a byte stream, selected by a mode register.
// ----------------------------------------------------------------------------
// A result passes through the input register and the result queue before
// it can be taken. Throughput: one byte per cycle while the queue has room;
// a byte that gives two results is absorbed by an eight-entry result queue.
// Reset: mode returns to CRC-32, all message state clears, the queue empties.
// ----------------------------------------------------------------------------
module error_check_code_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ecc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output ecc_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_data
);
  import ecc_pkg::*;

  logic [2:0]          code_mode;
  logic                accept;
  logic                held;
  ecc_push_t           push;
  logic [QUEUE_CW-1:0] level;
  logic [QUEUE_CW:0]   claimed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_mode <= MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      code_mode <= cfg_data;
    end
  end

  // A held byte may still push two results, so room for it is reserved.
  assign claimed  = {1'b0, level} + {{(QUEUE_CW-1){1'b0}}, held, 1'b0};
  assign in_stall = (claimed > {1'b0, QUEUE_LIMIT});
  assign accept   = in_valid & ~in_stall;

  ecc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (in_item),
    .code_mode (code_mode),
    .held      (held),
    .push      (push)
  );

  ecc_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .level     (level)
  );

  assert property (@(posedge clk) disable iff (rst)
    level <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("result queue overflow");

  assert property (@(posedge clk) disable iff (rst)
    push.push_b |-> push.push_a)
    else $error("second result without a first");

  assert property (@(posedge clk) disable iff (rst)
    accept |=> held)
    else $error("accepted item not held");

  assert property (@(posedge clk) disable iff (rst)
    (push.push_a || push.push_b) |-> held)
    else $error("result pushed without a held item");

endmodule

// ===== verif/ecc_result_checker.sv =====
// ----------------------------------------------------------------------------
// Error check code result checker
// Watches the byte, result and mode channels of the code generator. It keeps
// its own copy of the mode and of every running accumulator, predicts the
// codes that each accepted byte produces, and compares each accepted result
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ecc_result_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  ecc_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  ecc_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_data,
  output int                 pending,
  output int                 errors
);
  import ecc_pkg::*;

  logic [2:0]  mode;
  logic [31:0] crc;
  logic [15:0] csum;
  logic [7:0]  high_byte;
  logic        odd_phase;
  logic        total_par;
  logic [7:0]  column_par;
  out_item_t   expected_codes[$];
  out_item_t   oldest;

  task automatic clear_message();
    crc = CRC_INIT;
    csum = '0;
    high_byte = '0;
    odd_phase = 1'b0;
    total_par = 1'b0;
    column_par = '0;
  endtask

  task automatic predict_codes(input in_item_t it);
    logic [7:0]  b;
    logic        row;
    logic [3:0]  ham;
    logic [15:0] word;
    logic [16:0] wide_sum;
    logic        add_word;
    b = it.data_byte;
    row = ^b;
    total_par = total_par ^ row;
    column_par = column_par ^ b;
    crc = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
    add_word = 1'b0;
    word = '0;
    if (!odd_phase) begin
      high_byte = b;
      odd_phase = 1'b1;
      if (it.last_byte) begin
        word = {b, 8'h00};
        add_word = 1'b1;
      end
    end else begin
      word = {high_byte, b};
      add_word = 1'b1;
      odd_phase = 1'b0;
    end
    if (add_word) begin
      wide_sum = {1'b0, csum} + {1'b0, word};
      csum = wide_sum[15:0] + {15'd0, wide_sum[16]};
    end
    ham = {b[7] ^ b[6] ^ b[4] ^ b[3] ^ b[1],
           b[7] ^ b[5] ^ b[4] ^ b[2] ^ b[1],
           b[6] ^ b[5] ^ b[4] ^ b[0],
           b[3] ^ b[2] ^ b[1] ^ b[0]};
    case (mode)
      MODE_PARITY: begin
        if (it.last_byte) begin
          expected_codes.push_back(out_item_t'{RES_MESSAGE, {31'd0, total_par}, LEN_PARITY, 1'b1});
        end
      end
      MODE_PARITY2D: begin
        expected_codes.push_back(out_item_t'{RES_PER_BYTE, {31'd0, row}, LEN_PARITY, 1'b0});
        if (it.last_byte) begin
          expected_codes.push_back(out_item_t'{RES_MESSAGE, {24'd0, column_par}, LEN_COLUMN,
                                               1'b1});
        end
      end
      MODE_CRC32: begin
        if (it.last_byte) begin
          expected_codes.push_back(out_item_t'{RES_MESSAGE, ~crc, LEN_CRC, 1'b1});
        end
      end
      MODE_HAMMING: begin
        expected_codes.push_back(out_item_t'{RES_PER_BYTE, {28'd0, ham}, LEN_HAMMING,
                                             it.last_byte});
      end
      MODE_CHECKSUM: begin
        if (it.last_byte) begin
          expected_codes.push_back(out_item_t'{RES_MESSAGE, {16'd0, ~csum}, LEN_CHECKSUM, 1'b1});
        end
      end
      default: begin
      end
    endcase
    if (it.last_byte) begin
      clear_message();
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      mode = MODE_RESET;
      clear_message();
      expected_codes.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (expected_codes.size() == 0) begin
          errors++;
          $display("%0t: result %h arrived, expected none", $time, out_item);
        end else begin
          oldest = expected_codes.pop_front();
          if (out_item.result_type !== oldest.result_type) begin
            errors++;
            $display("%0t: result_type expected %0d, got %0d", $time,
                     oldest.result_type, out_item.result_type);
          end
          if (out_item.code_value !== oldest.code_value) begin
            errors++;
            $display("%0t: code_value expected %h, got %h", $time,
                     oldest.code_value, out_item.code_value);
          end
          if (out_item.code_length !== oldest.code_length) begin
            errors++;
            $display("%0t: code_length expected %0d, got %0d", $time,
                     oldest.code_length, out_item.code_length);
          end
          if (out_item.end_of_codes !== oldest.end_of_codes) begin
            errors++;
            $display("%0t: end_of_codes expected %0d, got %0d", $time,
                     oldest.end_of_codes, out_item.end_of_codes);
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_codes(in_item);
      end
      pending <= expected_codes.size();
    end
  end

endmodule

// ===== verif/error_check_code_generator_test.sv =====
// ----------------------------------------------------------------------------
// Error check code generator testbench
// Drives messages of bytes in every code mode, including the undefined ones
// and mode changes inside a message, with bursty input and a stalling
// receiver. A separate checker predicts and compares all results.
// ----------------------------------------------------------------------------
module error_check_code_generator_test;
  import ecc_pkg::*;

  localparam int         ITEM_TARGET    = 1250;
  localparam int         IDLE_LIMIT     = 2000;
  localparam int         SETTLE_CYCLES  = 4;
  localparam int         DRAIN_CYCLES   = 10;
  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  in_item_t   in_item = '0;
  logic       out_stall = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [2:0] cfg_data = '0;
  logic       in_stall;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_ready;
  int         pending;
  int         errors;
  int         idle_cycles = 0;
  int         burst_left = 0;
  int         stall_left = 0;
  logic [1:0] stall_style = '0;
  int         sent = 0;

  error_check_code_generator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ecc_result_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .errors    (errors)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= 2'($urandom_range(0, 3));
      stall_left <= $urandom_range(1, 40);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_left > 28);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= in_item_t'{b, last};
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [2:0] m);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int         len;
    int         switch_at;
    logic [7:0] b;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'hFF, 1'b1);
    write_mode(MODE_PARITY);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    write_mode(MODE_PARITY2D);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b1);
    write_mode(MODE_HAMMING);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    write_mode(MODE_CHECKSUM);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b1);
    write_mode(MODE_UNUSED_HI);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);
    write_mode(MODE_CRC32);
    send_byte(8'h00, 1'b1);
    write_mode(MODE_PARITY);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    write_mode(MODE_CHECKSUM);
    send_byte(8'h56, 1'b1);
    write_mode(MODE_UNUSED_LO);
    send_byte(8'h3C, 1'b1);

    while (sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) begin
        write_mode(3'($urandom_range(0, 7)));
      end else begin
        write_mode(3'($urandom_range(0, 4)));
      end
      repeat ($urandom_range(1, 6)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 8);
        switch_at = ($urandom_range(0, 7) == 0 && len > 1) ? $urandom_range(1, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
          if (i == switch_at) begin
            write_mode(3'($urandom_range(0, 7)));
          end
          if ($urandom_range(0, 7) == 0) begin
            b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          end else begin
            b = 8'($urandom_range(0, 255));
          end
          send_byte(b, i == len - 1);
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
